// ===== rtl/core/b64d_pkg.sv =====
// Shared types, codes and the character classifier for the Base64 stream decoder.
// No dependencies. Imported by every module under rtl/core.
`default_nettype none

package b64d_pkg;

  // Queue between front and back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Alphabet anchors.
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5a;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7a;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChPad    = 8'h3d;

  // Class of one text character.
  typedef enum logic [1:0] {
    SYM_VALUE,
    SYM_PAD,
    SYM_BAD
  } sym_kind_t;

  // End-of-stream status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_BAD_PAD  = 2'd3
  } status_t;

  // One classified character as it travels through the queue.
  typedef struct packed {
    sym_kind_t  kind;
    logic [5:0] value;
    logic       last;
  } sym_item_t;

  // Map one character to its class and 6-bit value.
  function automatic sym_item_t classify(input logic [7:0] ch, input logic last);
    sym_item_t r;
    r.kind  = SYM_BAD;
    r.value = 6'd0;
    r.last  = last;
    if (ch >= ChUpperA && ch <= ChUpperZ) begin
      r.kind  = SYM_VALUE;
      r.value = 6'(ch - ChUpperA);
    end else if (ch >= ChLowerA && ch <= ChLowerZ) begin
      r.kind  = SYM_VALUE;
      r.value = 6'(ch - ChLowerA + 8'd26);
    end else if (ch >= ChDigit0 && ch <= ChDigit9) begin
      r.kind  = SYM_VALUE;
      r.value = 6'(ch - ChDigit0 + 8'd52);
    end else if (ch == ChPlus) begin
      r.kind  = SYM_VALUE;
      r.value = 6'd62;
    end else if (ch == ChSlash) begin
      r.kind  = SYM_VALUE;
      r.value = 6'd63;
    end else if (ch == ChPad) begin
      r.kind  = SYM_PAD;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/b64d_front.sv =====
// Front end: accepts text characters and classifies them into queue items.
// Depends on b64d_pkg (classify, sym_item_t).
`default_nettype none

module b64d_front
  import b64d_pkg::*;
(
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // text_char
  input  wire logic       in_tlast,   // end_of_text
  input  wire logic       q_full,
  output logic            q_push,
  output sym_item_t       q_wdata
);

  // Take a character whenever the queue has room.
  assign in_tready = ~q_full;
  assign q_push    = in_tvalid & ~q_full;

  // Classify the incoming character.
  assign q_wdata = classify(in_tdata, in_tlast);

endmodule

`default_nettype wire

// ===== rtl/core/b64d_queue.sv =====
// Small register queue between the front and back of the decoder.
// Depends on b64d_pkg (QueueDepth, sym_item_t).
`default_nettype none

module b64d_queue
  import b64d_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire sym_item_t wdata,
  input  wire logic      pop,
  output sym_item_t      rdata,
  output logic           full,
  output logic           empty
);

  sym_item_t               mem_r [QueueDepth];
  logic [QueuePtrW-1:0]    wptr_r, wptr_nxt;
  logic [QueuePtrW-1:0]    rptr_r, rptr_nxt;
  logic [QueueCntW-1:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == QueueCntW'(QueueDepth));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  // Advance pointers and count.
  always_comb begin
    wptr_nxt = push ? QueuePtrW'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt = pop  ? QueuePtrW'(rptr_r + 1'b1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = QueueCntW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = QueueCntW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store entries.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue read while empty");
  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    ((wptr_r - rptr_r) == cnt_r[QueuePtrW-1:0]))
    else $error("queue count disagrees with pointers");

endmodule

`default_nettype wire

// ===== rtl/core/b64d_back.sv =====
// Back end: quad packing, error tracking and the output register.
// Depends on b64d_pkg (sym_item_t, status_t).
`default_nettype none

module b64d_back
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_empty,
  input  wire sym_item_t  q_rdata,
  output logic            q_pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // data_byte
  output logic [2:0]      out_tuser,  // [0] byte_valid, [2:1] status
  output logic            out_tlast   // end_of_stream
);

  logic [1:0] pos_r, pos_nxt;
  logic [5:0] pend_r, pend_nxt;
  status_t    err_r, err_nxt;
  logic [1:0] pad_r, pad_nxt;

  logic       ov_r, ov_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic       obv_r, obv_nxt;
  logic       olast_r, olast_nxt;
  status_t    ost_r, ost_nxt;

  logic       load_ok;
  logic       have;
  logic [7:0] byte_v;
  logic [1:0] pos_inc;
  status_t    st_v;
  sym_item_t  it;

  // Pop whenever the output register is free or being drained.
  assign load_ok = ~ov_r | out_tready;
  assign q_pop   = ~q_empty & load_ok;
  assign it      = q_rdata;
  assign pos_inc = 2'(pos_r + 1'b1);

  // Decode one symbol against the quad state.
  always_comb begin
    pend_nxt = pend_r;
    err_nxt  = err_r;
    pad_nxt  = pad_r;
    have     = 1'b0;
    byte_v   = 8'd0;
    case (it.kind)
      SYM_BAD: begin
        err_nxt = ST_BAD_CHAR;
      end
      SYM_PAD: begin
        if ((pos_r < 2'd2 || (pad_r != 2'd0 && pos_r == 2'd2)) && err_r == ST_OK) begin
          err_nxt = ST_BAD_PAD;
        end
        if (pad_r != 2'd3) begin
          pad_nxt = 2'(pad_r + 1'b1);
        end
      end
      SYM_VALUE: begin
        if (pad_r != 2'd0) begin
          if (err_r == ST_OK) begin
            err_nxt = ST_BAD_PAD;
          end
        end else begin
          case (pos_r)
            2'd0: begin
              pend_nxt = it.value;
            end
            2'd1: begin
              byte_v   = {pend_r, it.value[5:4]};
              pend_nxt = {2'b00, it.value[3:0]};
              have     = 1'b1;
            end
            2'd2: begin
              byte_v   = {pend_r[3:0], it.value[5:2]};
              pend_nxt = {4'b0000, it.value[1:0]};
              have     = 1'b1;
            end
            default: begin
              byte_v   = {pend_r[1:0], it.value};
              pend_nxt = 6'd0;
              have     = 1'b1;
            end
          endcase
        end
      end
      default: begin
        err_nxt = err_r;
      end
    endcase

    // Final status from the updated error and position.
    if (err_nxt != ST_OK) begin
      st_v = err_nxt;
    end else if (pos_inc != 2'd0) begin
      st_v = ST_BAD_LEN;
    end else begin
      st_v = ST_OK;
    end

    pos_nxt = pos_inc;
    // Return to the idle state after the closing character.
    if (it.last) begin
      pos_nxt  = 2'd0;
      pend_nxt = 6'd0;
      err_nxt  = ST_OK;
      pad_nxt  = 2'd0;
    end
  end

  // Output register: load a result, or drop the valid once transferred.
  always_comb begin
    ov_nxt    = ov_r & ~out_tready;
    obyte_nxt = obyte_r;
    obv_nxt   = obv_r;
    olast_nxt = olast_r;
    ost_nxt   = ost_r;
    if (q_pop && (have || it.last)) begin
      ov_nxt    = 1'b1;
      obyte_nxt = byte_v;
      obv_nxt   = have;
      olast_nxt = it.last;
      ost_nxt   = it.last ? st_v : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 2'd0;
      pend_r <= 6'd0;
      err_r  <= ST_OK;
      pad_r  <= 2'd0;
      ov_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        pos_r  <= pos_nxt;
        pend_r <= pend_nxt;
        err_r  <= err_nxt;
        pad_r  <= pad_nxt;
      end
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obyte_r <= obyte_nxt;
    obv_r   <= obv_nxt;
    olast_r <= olast_nxt;
    ost_r   <= ost_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = obyte_r;
  assign out_tuser  = {ost_r, obv_r};
  assign out_tlast  = olast_r;

  a_result_has_content: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (obv_r || olast_r))
    else $error("result without byte or end of stream");
  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !olast_r) |-> (ost_r == ST_OK))
    else $error("status set on a result that does not close the stream");
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && it.last) |=> (pos_r == 2'd0 && pad_r == 2'd0 && err_r == ST_OK))
    else $error("state not cleared after end of text");
  a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |-> !q_pop)
    else $error("symbol taken while result register is held");

endmodule

`default_nettype wire

// ===== rtl/core/base64_stream_decoder.sv =====
// Top level of the Base64 stream decoder: front classifier, queue, back packer.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
//
//  channel | dir | tdata              | tuser                      | tlast
//  in_     | in  | [7:0] text_char    | -                          | end_of_text
//  out_    | out | [7:0] data_byte    | [0] byte_valid [2:1] status | end_of_stream
//
// One character per cycle sustained while the queue is not full. With the queue empty, a
// transferred character is written into the queue, then packed into the output register,
// from which its result can transfer out.
// Reset clears the queue, quad state and output valid; no clearing pass.
// A stalled output holds its register; the four-entry queue absorbs input meanwhile,
// and in_tready drops only when the queue is full.
`default_nettype none

module base64_stream_decoder
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // text_char
  input  wire logic       in_tlast,   // end_of_text
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // data_byte
  output logic [2:0]      out_tuser,  // [0] byte_valid, [2:1] status
  output logic            out_tlast   // end_of_stream
);

  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  sym_item_t q_wdata;
  sym_item_t q_rdata;

  b64d_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  b64d_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_base64_stream_decoder.sv =====
// Self-checking testbench for base64_stream_decoder: directed table, then random text streams.
// Depends on b64d_pkg for status codes and alphabet anchors; the decoder itself is a black box.
module tb_base64_stream_decoder
  import b64d_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned MaxReports  = 10;

  // One decoded result as the output channel carries it.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_stream;
    status_t    status;
  } b64_result_t;

  // Per-character note: a pinned note replaces the predicted result.
  typedef struct packed {
    logic        pinned;
    logic        has_res;
    b64_result_t res;
  } char_note_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    char_note_t note;
  } char_row_t;

  localparam b64_result_t Quiet   = '0;
  localparam char_note_t  Predict = '0;

  // Directed walk: alphabet extremes, padding, and at least one stream per status code.
  localparam int unsigned WalkLen = 24;
  localparam char_row_t Walk [WalkLen] = '{
    // "A/+/": lowest and highest sextets
    '{ChUpperA, 1'b0, '{1'b1, 1'b0, Quiet}},
    '{ChSlash,  1'b0, Predict},
    '{ChPlus,   1'b0, Predict},
    '{ChSlash,  1'b1, Predict},
    // "Zz09": range ends of each letter and digit group
    '{ChUpperZ, 1'b0, Predict},
    '{ChLowerZ, 1'b0, Predict},
    '{ChDigit0, 1'b0, Predict},
    '{ChDigit9, 1'b1, Predict},
    // "QQ==": double pad closes a clean stream
    '{8'h51,    1'b0, Predict},
    '{8'h51,    1'b0, '{1'b1, 1'b1, '{8'h41, 1'b1, 1'b0, ST_OK}}},
    '{ChPad,    1'b0, '{1'b1, 1'b0, Quiet}},
    '{ChPad,    1'b1, '{1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK}}},
    // lone NUL: invalid character
    '{8'h00,    1'b1, '{1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BAD_CHAR}}},
    // bytes at the top of the range mixed with valid ones
    '{8'hff,    1'b0, Predict},
    '{8'h51,    1'b0, Predict},
    '{8'h80,    1'b0, Predict},
    '{ChPad,    1'b1, '{1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BAD_CHAR}}},
    // "AB": incomplete quad
    '{ChUpperA, 1'b0, Predict},
    '{8'h42,    1'b1, '{1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, ST_BAD_LEN}}},
    // pad in the first position
    '{ChPad,    1'b1, '{1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BAD_PAD}}},
    // "QQ=A": data after a pad
    '{8'h51,    1'b0, Predict},
    '{8'h51,    1'b0, Predict},
    '{ChPad,    1'b0, Predict},
    '{ChUpperA, 1'b1, '{1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BAD_PAD}}}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // text_char
  logic       in_tlast;   // end_of_text
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;  // data_byte
  logic [2:0] out_tuser;  // [0] byte_valid, [2:1] status
  logic       out_tlast;  // end_of_stream

  // Decoder state mirror.
  logic [1:0] quad_pos;
  logic [5:0] carry_bits;
  status_t    held_err;
  logic [1:0] pad_count;

  b64_result_t pending_results[$];
  char_note_t  char_notes[$];

  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  int hold_asked   = 0;
  int hold_served  = 0;
  int hold_left    = 0;

  int mismatches   = 0;
  int sent_chars   = 0;
  int streams_sent = 0;
  int bytes_seen   = 0;
  int closes [4]   = '{0, 0, 0, 0};

  base64_stream_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  // Decode one character against the mirrored state; returns 1 when a result is due.
  function automatic bit decode_char(input logic [7:0] ch, input logic eot,
                                     output b64_result_t res);
    logic [5:0] six;
    logic [1:0] pos;
    bit         is_val;
    bit         is_pad;
    bit         produced;
    six      = 6'd0;
    pos      = quad_pos;
    is_val   = 1'b1;
    is_pad   = 1'b0;
    produced = 1'b0;
    res      = '0;
    if (ch >= ChUpperA && ch <= ChUpperZ) six = 6'(ch - ChUpperA);
    else if (ch >= ChLowerA && ch <= ChLowerZ) six = 6'(ch - ChLowerA + 8'd26);
    else if (ch >= ChDigit0 && ch <= ChDigit9) six = 6'(ch - ChDigit0 + 8'd52);
    else if (ch == ChPlus) six = 6'd62;
    else if (ch == ChSlash) six = 6'd63;
    else begin
      is_val = 1'b0;
      is_pad = (ch == ChPad);
    end

    if (!is_val && !is_pad) begin
      held_err = ST_BAD_CHAR;
    end else if (is_pad) begin
      // pad is legal only in the last two slots, and the third only after none
      if (pos < 2'd2 || (pad_count != 2'd0 && pos == 2'd2)) begin
        if (held_err == ST_OK) held_err = ST_BAD_PAD;
      end
      if (pad_count != 2'd3) pad_count = pad_count + 2'd1;
    end else if (pad_count != 2'd0) begin
      if (held_err == ST_OK) held_err = ST_BAD_PAD;
    end else begin
      case (pos)
        2'd0: begin
          carry_bits = six;
        end
        2'd1: begin
          res.data_byte = {carry_bits, six[5:4]};
          carry_bits    = {2'b00, six[3:0]};
          produced      = 1'b1;
        end
        2'd2: begin
          res.data_byte = {carry_bits[3:0], six[5:2]};
          carry_bits    = {4'b0000, six[1:0]};
          produced      = 1'b1;
        end
        default: begin
          res.data_byte = {carry_bits[1:0], six};
          carry_bits    = 6'd0;
          produced      = 1'b1;
        end
      endcase
    end
    quad_pos = pos + 2'd1;
    res.byte_valid = produced;

    // Close the stream and clear for the next one.
    if (eot) begin
      res.end_of_stream = 1'b1;
      if (held_err != ST_OK) res.status = held_err;
      else if (quad_pos != 2'd0) res.status = ST_BAD_LEN;
      else res.status = ST_OK;
      quad_pos   = 2'd0;
      carry_bits = 6'd0;
      held_err   = ST_OK;
      pad_count  = 2'd0;
    end
    return produced || eot;
  endfunction

  task automatic check_field(input string name, input int want, input int seen);
    if (want != seen) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, name, want, seen);
    end
  endtask

  // Offer one character and hold it until the transfer.
  task automatic put_char(input logic [7:0] ch, input logic eot, input char_note_t note);
    while (src_idle_en && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    char_notes.push_back(note);
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent_chars++;
  endtask

  // Switch idling on both sides, optionally ask the sink for a long hold-off.
  task automatic set_idling(input bit on, input bit hold);
    in_tvalid <= 1'b0;
    @(posedge clk);
    src_idle_en  = on;
    sink_idle_en = on;
    if (hold) hold_asked++;
    @(negedge clk);
  endtask

  // Build one random text: mostly well-formed quads, some short, noisy or badly padded.
  task automatic send_random_stream();
    logic [7:0] text[$];
    int mode;
    int nq;
    int v;
    logic [7:0] c;
    mode = $urandom_range(99);
    nq   = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
    for (int k = 0; k < 4 * nq; k++) begin
      v = $urandom_range(63);
      c = (v < 26) ? 8'(ChUpperA + v) :
          (v < 52) ? 8'(ChLowerA + v - 26) :
          (v < 62) ? 8'(ChDigit0 + v - 52) :
          (v == 62) ? ChPlus : ChSlash;
      text.push_back(c);
    end
    if (mode < 72) begin
      case ($urandom_range(2))
        1: text[text.size()-1] = ChPad;
        2: begin
          text[text.size()-1] = ChPad;
          text[text.size()-2] = ChPad;
        end
        default: ;
      endcase
    end else if (mode < 80) begin
      repeat ($urandom_range(1, 3)) void'(text.pop_back());
    end else if (mode < 90) begin
      repeat ($urandom_range(1, 3)) text[$urandom_range(text.size()-1)] = 8'($urandom_range(255));
    end else begin
      text[$urandom_range(text.size()-1)] = ChPad;
      if ($urandom_range(1) == 1)
        repeat ($urandom_range(1, 5)) text.push_back(8'(ChUpperA + $urandom_range(25)));
    end
    foreach (text[i]) put_char(text[i], i == text.size() - 1, Predict);
    streams_sent++;
  endtask

  // Sink: random stalls, or a counted hold-off when asked.
  always @(negedge clk) begin
    if (hold_served != hold_asked) begin
      hold_left = HoldCycles;
      hold_served++;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(sink_idle_en && $urandom_range(99) < 26);
    end
  end

  // Predict on every input transfer, check every output transfer.
  always @(posedge clk) begin
    char_note_t  note;
    b64_result_t want;
    b64_result_t seen;
    bit          due;
    if (rst_n && in_tvalid && in_tready) begin
      note = (char_notes.size() != 0) ? char_notes.pop_front() : Predict;
      due  = decode_char(in_tdata, in_tlast, want);
      if (note.pinned) begin
        due  = note.has_res;
        want = note.res;
      end
      if (due) pending_results.push_back(want);
    end
    if (rst_n && out_tvalid && out_tready) begin
      seen.data_byte     = out_tdata;
      seen.byte_valid    = out_tuser[0];
      seen.end_of_stream = out_tlast;
      seen.status        = status_t'(out_tuser[2:1]);
      if (seen.byte_valid) bytes_seen++;
      if (seen.end_of_stream) closes[seen.status]++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: result with nothing expected: data 0x%0h user 0x%0h last %0b",
                   $realtime, out_tdata, out_tuser, out_tlast);
      end else begin
        want = pending_results.pop_front();
        check_field("data_byte", want.data_byte, seen.data_byte);
        check_field("byte_valid", want.byte_valid, seen.byte_valid);
        check_field("end_of_stream", want.end_of_stream, seen.end_of_stream);
        check_field("status", want.status, seen.status);
      end
    end
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tlast   = 1'b0;
    quad_pos   = 2'd0;
    carry_bits = 6'd0;
    held_err   = ST_OK;
    pad_count  = 2'd0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk.
    for (int i = 0; i < WalkLen; i++) begin
      put_char(Walk[i].ch, Walk[i].eot, Walk[i].note);
      if (Walk[i].eot) streams_sent++;
    end

    // Random streams: idling with a hold-off, a clean stretch, idling again.
    set_idling(1'b1, 1'b1);
    while (sent_chars < WalkLen + 700) send_random_stream();
    set_idling(1'b0, 1'b0);
    while (sent_chars < WalkLen + 1300) send_random_stream();
    set_idling(1'b1, 1'b1);
    while (sent_chars < WalkLen + 1900) send_random_stream();
    in_tvalid <= 1'b0;

    // Drain, then give stray results time to show up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d characters in %0d streams, %0d bytes decoded.",
             sent_chars, streams_sent, bytes_seen);
    $display("Stream closes: %0d ok, %0d bad char, %0d bad length, %0d bad pad; %0d mismatches.",
             closes[ST_OK], closes[ST_BAD_CHAR], closes[ST_BAD_LEN], closes[ST_BAD_PAD],
             mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
